### hw/rtl/xyl_pkg.sv
package xyl_pkg;

  // Fixed field widths of the stream and configuration payloads.
  localparam int SIDE_W       = 7;
  localparam int ROW_W        = 6;
  localparam int PORT_ANGLE_W = 16;
  localparam int ENERGY_W     = 18;
  localparam int COS_W        = 16;

  localparam logic [SIDE_W-1:0] SIDE_RESET = 7'd64;

  // Cosine series constants in Q30.
  localparam logic [63:0] HALF_PI_Q30  = 64'd1686629713;
  localparam logic [63:0] ONE_Q30      = 64'd1 << 30;
  localparam int          TAYLOR_TERMS = 12;
  localparam int unsigned TAYLOR_DIV [TAYLOR_TERMS] =
    '{2, 12, 30, 56, 90, 132, 182, 240, 306, 380, 462, 552};

  typedef enum logic [1:0] {
    OP_WRITE  = 2'd0,
    OP_READ   = 2'd1,
    OP_ENERGY = 2'd2,
    OP_TRIAL  = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    RD_CENTRE,
    RD_LEFT,
    RD_RIGHT,
    RD_UP,
    RD_DOWN
  } rd_sel_e;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ISSUE,
    ST_FINISH
  } ctl_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    accept;
    logic    clr_wr;
    logic    lat_wr;
    logic    rd_en;
    rd_sel_e rd_sel;
    logic    load_out;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clr_last;
    logic bad;
    op_e  op;
    logic busy;
    logic out_free;
  } dp_status_t;

  // Quarter-wave cosine in Q14 for step m of a quarter turn split into
  // 2**qshift steps. Only used to build constant tables at elaboration.
  function automatic logic [COS_W-2:0] quad_cos(input logic [63:0] m,
                                                input int unsigned qshift);
    logic [63:0]        th;
    logic [63:0]        th2;
    logic [63:0]        term;
    logic signed [63:0] sum;
    logic [63:0]        rnd;
    th   = (HALF_PI_Q30 * m) >> qshift;
    th2  = (th * th) >> 30;
    term = ONE_Q30;
    sum  = $signed(ONE_Q30);
    for (int n = 0; n < TAYLOR_TERMS; n++) begin
      term = ((term * th2) >> 30) / TAYLOR_DIV[n];
      if ((n % 2) == 0) begin
        sum = sum - $signed(term);
      end else begin
        sum = sum + $signed(term);
      end
    end
    if (sum < 0) begin
      sum = '0;
    end
    if (sum > $signed(ONE_Q30)) begin
      sum = $signed(ONE_Q30);
    end
    rnd = ($unsigned(sum) + (64'd1 << 15)) >> 16;
    return rnd[COS_W-2:0];
  endfunction

endpackage

### hw/rtl/xyl_ram.sv
module xyl_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // One write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### hw/rtl/xyl_ctrl.sv
module xyl_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_valid_i,
  output logic                s_ready_o,
  input  xyl_pkg::dp_status_t st_i,
  output xyl_pkg::dp_cmd_t    cmd_o
);
  import xyl_pkg::*;

  ctl_state_e state_q, state_d;
  rd_sel_e    step_q, step_d;

  // State and read step registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      step_q  <= RD_CENTRE;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    unique case (state_q)
      ST_CLEAR: begin
        if (st_i.clr_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (s_valid_i) begin
          state_d = ST_ISSUE;
          step_d  = RD_CENTRE;
        end
      end
      ST_ISSUE: begin
        priority if (st_i.bad || st_i.op == OP_WRITE) begin
          state_d = ST_FINISH;
        end else if (st_i.op == OP_READ || step_q == RD_DOWN) begin
          state_d = ST_FINISH;
          step_d  = RD_CENTRE;
        end else begin
          unique case (step_q)
            RD_CENTRE: step_d = RD_LEFT;
            RD_LEFT:   step_d = RD_RIGHT;
            RD_RIGHT:  step_d = RD_UP;
            RD_UP:     step_d = RD_DOWN;
            default:   step_d = RD_CENTRE;
          endcase
        end
      end
      ST_FINISH: begin
        if (!st_i.busy && st_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
    endcase
  end

  // Outputs.
  always_comb begin
    cmd_o     = '0;
    s_ready_o = 1'b0;
    unique case (state_q)
      ST_CLEAR: begin
        cmd_o.clr_wr = 1'b1;
      end
      ST_IDLE: begin
        s_ready_o    = 1'b1;
        cmd_o.accept = s_valid_i;
      end
      ST_ISSUE: begin
        if (!st_i.bad) begin
          if (st_i.op == OP_WRITE) begin
            cmd_o.lat_wr = 1'b1;
          end else begin
            cmd_o.rd_en  = 1'b1;
            cmd_o.rd_sel = step_q;
          end
        end
      end
      ST_FINISH: begin
        cmd_o.load_out = !st_i.busy && st_i.out_free;
      end
    endcase
  end

endmodule

### hw/rtl/xyl_dp.sv
module xyl_dp #(
  parameter int MAX_SIDE       = 64,
  parameter int ANGLE_BITS     = 16,
  parameter int COS_TABLE_BITS = 10
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  xyl_pkg::dp_cmd_t                     cmd_i,
  output xyl_pkg::dp_status_t                  st_o,
  input  logic                                 cfg_we_i,
  input  logic [xyl_pkg::SIDE_W-1:0]           cfg_wdata_i,
  input  logic [1:0]                           in_op_i,
  input  logic [xyl_pkg::ROW_W-1:0]            in_row_i,
  input  logic [xyl_pkg::ROW_W-1:0]            in_col_i,
  input  logic [xyl_pkg::PORT_ANGLE_W-1:0]     in_angle_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic [xyl_pkg::PORT_ANGLE_W-1:0]     out_stored_o,
  output logic signed [xyl_pkg::ENERGY_W-1:0]  out_energy_o,
  output logic                                 out_bad_o
);
  import xyl_pkg::*;

  localparam int DEPTH   = MAX_SIDE * MAX_SIDE;
  localparam int ADDR_W  = $clog2(DEPTH);
  localparam int LW      = $clog2(MAX_SIDE + 1);
  localparam int CW      = (LW > ROW_W + 1) ? LW : ROW_W + 1;
  localparam int CTB     = COS_TABLE_BITS;
  localparam int QUARTER = 1 << (CTB - 2);

  typedef logic [COS_W-2:0] qtab_t [QUARTER+1];

  function automatic qtab_t build_qtab();
    qtab_t t;
    for (int m = 0; m <= QUARTER; m++) begin
      t[m] = quad_cos(64'(m), CTB - 2);
    end
    return t;
  endfunction

  localparam qtab_t QTAB = build_qtab();

  // Configuration and item registers.
  logic [SIDE_W-1:0]           side_q;
  op_e                         op_q;
  logic [CW-1:0]               row_q, col_q;
  logic [ANGLE_BITS-1:0]       angle_q;
  logic                        bad_q;
  logic [ANGLE_BITS-1:0]       stored_q, centre_q;
  logic signed [ENERGY_W-1:0]  acc_q;
  logic signed [COS_W-1:0]     cos_q;
  logic                        rd_vld_q, rd_centre_q, cos_vld_q;
  logic [ADDR_W-1:0]           clr_cnt_q;
  logic                        out_valid_q;
  logic [PORT_ANGLE_W-1:0]     out_stored_q;
  logic signed [ENERGY_W-1:0]  out_energy_q;
  logic                        out_bad_q;

  logic [CW-1:0]         l_eff, in_row_c, in_col_c;
  logic [CW-1:0]         lc, rc, ur, dr, row_sel, col_sel;
  logic [ADDR_W-1:0]     addr_ctr, addr_rd, waddr;
  logic                  in_bad, we, out_free;
  logic [ANGLE_BITS-1:0] wdata, rdata, diff;
  logic [CTB-1:0]        idx;
  logic [1:0]            quad;
  logic [CTB-2:0]        m_idx;
  logic [COS_W-2:0]      mag;
  logic signed [COS_W-1:0] cos_val;

  // Effective side saturates at the lattice size.
  assign l_eff    = (CW'(side_q) > CW'(MAX_SIDE)) ? CW'(MAX_SIDE) : CW'(side_q);
  assign in_row_c = CW'(in_row_i);
  assign in_col_c = CW'(in_col_i);
  assign in_bad   = (in_row_c >= l_eff) || (in_col_c >= l_eff);

  // Wrapped neighbour coordinates.
  assign lc = (col_q == '0) ? l_eff - CW'(1) : col_q - CW'(1);
  assign rc = (col_q + CW'(1) == l_eff) ? '0 : col_q + CW'(1);
  assign ur = (row_q == '0) ? l_eff - CW'(1) : row_q - CW'(1);
  assign dr = (row_q + CW'(1) == l_eff) ? '0 : row_q + CW'(1);

  always_comb begin
    row_sel = row_q;
    col_sel = col_q;
    unique case (cmd_i.rd_sel)
      RD_CENTRE: ;
      RD_LEFT:   col_sel = lc;
      RD_RIGHT:  col_sel = rc;
      RD_UP:     row_sel = ur;
      RD_DOWN:   row_sel = dr;
      default:   ;
    endcase
  end

  assign addr_ctr = ADDR_W'(int'(row_q) * MAX_SIDE + int'(col_q));
  assign addr_rd  = ADDR_W'(int'(row_sel) * MAX_SIDE + int'(col_sel));

  // Lattice store: cleared after reset, then written by item writes.
  assign we    = cmd_i.clr_wr || cmd_i.lat_wr;
  assign waddr = cmd_i.clr_wr ? clr_cnt_q : addr_ctr;
  assign wdata = cmd_i.clr_wr ? '0 : angle_q;

  xyl_ram #(
    .WIDTH (ANGLE_BITS),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (cmd_i.rd_en),
    .raddr_i (addr_rd),
    .rdata_o (rdata)
  );

  // Cosine lookup from the angle difference.
  assign diff = rdata - centre_q;

  if (ANGLE_BITS >= CTB) begin : g_idx_shr
    assign idx = diff[ANGLE_BITS-1 -: CTB];
  end else begin : g_idx_shl
    assign idx = {diff, {(CTB - ANGLE_BITS){1'b0}}};
  end

  assign quad    = idx[CTB-1:CTB-2];
  assign m_idx   = quad[0] ? ((CTB-1)'(QUARTER) - {1'b0, idx[CTB-3:0]})
                           : {1'b0, idx[CTB-3:0]};
  assign mag     = QTAB[m_idx];
  assign cos_val = (quad == 2'd1 || quad == 2'd2) ? -$signed({1'b0, mag})
                                                   : $signed({1'b0, mag});

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side_q      <= SIDE_RESET;
      clr_cnt_q   <= '0;
      rd_vld_q    <= 1'b0;
      rd_centre_q <= 1'b0;
      cos_vld_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        side_q <= cfg_wdata_i;
      end
      if (cmd_i.clr_wr) begin
        clr_cnt_q <= clr_cnt_q + ADDR_W'(1);
      end
      rd_vld_q    <= cmd_i.rd_en;
      rd_centre_q <= cmd_i.rd_sel == RD_CENTRE;
      cos_vld_q   <= rd_vld_q && !rd_centre_q;
      if (cmd_i.load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Item, read-back and accumulate registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      op_q     <= op_e'(in_op_i);
      row_q    <= in_row_c;
      col_q    <= in_col_c;
      angle_q  <= ANGLE_BITS'(in_angle_i);
      bad_q    <= in_bad;
      stored_q <= '0;
      acc_q    <= '0;
    end else begin
      if (cmd_i.lat_wr) begin
        stored_q <= angle_q;
      end
      if (rd_vld_q && rd_centre_q) begin
        stored_q <= rdata;
        centre_q <= (op_q == OP_TRIAL) ? angle_q : rdata;
      end
      if (cos_vld_q) begin
        acc_q <= acc_q + ENERGY_W'(cos_q);
      end
    end
    if (rd_vld_q && !rd_centre_q) begin
      cos_q <= cos_val;
    end
    if (cmd_i.load_out) begin
      out_stored_q <= PORT_ANGLE_W'(stored_q);
      out_energy_q <= -acc_q;
      out_bad_q    <= bad_q;
    end
  end

  assign out_free = !out_valid_q || out_ready_i;

  assign st_o.clr_last = clr_cnt_q == ADDR_W'(DEPTH - 1);
  assign st_o.bad      = bad_q;
  assign st_o.op       = op_q;
  assign st_o.busy     = rd_vld_q || cos_vld_q;
  assign st_o.out_free = out_free;

  assign out_valid_o  = out_valid_q;
  assign out_stored_o = out_stored_q;
  assign out_energy_o = out_energy_q;
  assign out_bad_o    = out_bad_q;

endmodule

### hw/rtl/xy_lattice_site_energy.sv
// Local XY energy on a periodic square lattice of spin angles.
// Input stream: s_axis_tuser carries the operation (write, read, energy with
// the stored centre, energy with a trial centre); s_axis_tdata carries the
// row, column and angle. Each input beat gives exactly one output beat on
// m_axis: the stored angle, the negated sum of four neighbour cosines, and
// a bad-site flag in m_axis_tuser for coordinates at or beyond the side.
// The side length is set through cfg_we_i / cfg_wdata_i; the user is to
// write it only while idle, and the block itself does not enforce this.
// Items are handled one at a time. An energy query reads the centre and
// its four neighbours through the single read port of the lattice memory,
// one angle per cycle. After reset the lattice memory is cleared to zero,
// one site per cycle, and s_axis_tready stays low during that pass. The
// side length resets to 64.
// Results sit in an output register, so a stalled receiver holds m_axis
// steady; one further item can be taken and worked while it waits, and
// the block then holds that result until the register frees.
module xy_lattice_site_energy #(
  parameter int MAX_SIDE       = 64,
  parameter int ANGLE_BITS     = 16,
  parameter int COS_TABLE_BITS = 10
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [6:0]  cfg_wdata_i,    // side_length
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // site_row[5:0], site_col[11:6], angle[27:12]
  input  logic [1:0]  s_axis_tuser,   // op[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // stored_angle[15:0], energy[33:16]
  output logic        m_axis_tuser    // bad_site
);
  import xyl_pkg::*;

  dp_cmd_t                    cmd;
  dp_status_t                 st;
  logic [PORT_ANGLE_W-1:0]    out_stored;
  logic signed [ENERGY_W-1:0] out_energy;

  xyl_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .st_i      (st),
    .cmd_o     (cmd)
  );

  xyl_dp #(
    .MAX_SIDE       (MAX_SIDE),
    .ANGLE_BITS     (ANGLE_BITS),
    .COS_TABLE_BITS (COS_TABLE_BITS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .st_o         (st),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_op_i      (s_axis_tuser),
    .in_row_i     (s_axis_tdata[5:0]),
    .in_col_i     (s_axis_tdata[11:6]),
    .in_angle_i   (s_axis_tdata[27:12]),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_stored_o (out_stored),
    .out_energy_o (out_energy),
    .out_bad_o    (m_axis_tuser)
  );

  // Output beat packing, padded to whole bytes.
  assign m_axis_tdata = {6'b0, out_energy, out_stored};

endmodule

### hw/rtl/xyl_checker.sv
module xyl_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [39:0] m_axis_tdata,
  input logic        m_axis_tuser
);

  // A stalled output beat holds its payload.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output beat changed while stalled");

  // A bad site reports zero angle and zero energy.
  a_bad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == 40'd0)
    else $error("bad site with nonzero payload");

  // Energy stays within four unit cosines.
  a_energy_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> ($signed(m_axis_tdata[33:16]) >= -18'sd65536)
                   && ($signed(m_axis_tdata[33:16]) <= 18'sd65536))
    else $error("energy out of range");

  // The clearing pass keeps the input closed right after reset.
  a_clear_closed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$past(rst_ni) |-> !s_axis_tready)
    else $error("input open during clearing pass");

endmodule

bind xy_lattice_site_energy xyl_checker u_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

### dv/xy_lattice_site_energy_test.sv
`timescale 1ns / 1ps

module xy_lattice_site_energy_test;
  import xyl_pkg::*;

  localparam int LIMIT_CYCLES  = 400000;
  localparam int HOLD_CYCLES   = 400;
  localparam int SETTLE_CYCLES = 16;
  localparam int N_DIRECTED    = 25;
  localparam int N_PHASES      = 8;
  localparam int PHASE_ITEMS   = 106;

  // One result beat as the block should present it.
  typedef struct packed {
    logic [15:0]                angle_out;
    logic signed [ENERGY_W-1:0] energy;
    logic                       bad;
  } site_res_t;

  // A result that is typed in by hand replaces the computed one.
  typedef struct packed {
    logic      pinned;
    site_res_t res;
  } pinned_res_t;

  typedef struct {
    int          side;
    op_e         op;
    int          row;
    int          col;
    logic [15:0] angle;
    bit          pinned;
    int          e_angle;
    int          e_energy;
    int          e_bad;
  } directed_row_t;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        cfg_we_i      = 1'b0;
  logic [6:0]  cfg_wdata_i   = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata  = '0;
  logic [1:0]  s_axis_tuser  = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;
  logic        m_axis_tuser;

  // Local copy of the lattice, the cosine table and the side register.
  logic [15:0]  spin_mem [4096];
  int           cos_lut  [1024];
  logic [6:0]   side_cfg = 7'd64;

  site_res_t    site_res_q [$];
  pinned_res_t  pinned_res_q [$];
  int           err_count  = 0;
  int           cycle_cnt  = 0;
  int           send_gap_max = 0;
  int           rdy_gap_max  = 0;
  bit           hold_req     = 1'b0;

  // Directed items: extremes, every operation, wrap, bad sites and odd sides.
  directed_row_t directed_rows [N_DIRECTED] = '{
    '{64,  OP_READ,    0,  0, 16'h0000, 1, 16'h0000,      0, 0},
    '{64,  OP_ENERGY,  0,  0, 16'h1234, 1, 16'h0000, -65536, 0},
    '{64,  OP_TRIAL,  63, 63, 16'h8000, 1, 16'h0000,  65536, 0},
    '{64,  OP_WRITE,  63, 63, 16'hFFFF, 1, 16'hFFFF,      0, 0},
    '{64,  OP_READ,   63, 63, 16'h0000, 1, 16'hFFFF,      0, 0},
    '{64,  OP_WRITE,   0, 63, 16'h4000, 1, 16'h4000,      0, 0},
    '{64,  OP_WRITE,  63,  0, 16'hC000, 1, 16'hC000,      0, 0},
    '{64,  OP_ENERGY,  0,  0, 16'h0000, 0, 0, 0, 0},
    '{64,  OP_ENERGY, 63, 63, 16'h0000, 0, 0, 0, 0},
    '{16,  OP_WRITE,  16,  3, 16'h1234, 1, 16'h0000,      0, 1},
    '{16,  OP_READ,    3, 16, 16'h0000, 1, 16'h0000,      0, 1},
    '{16,  OP_TRIAL,  63, 63, 16'hFFFF, 1, 16'h0000,      0, 1},
    '{16,  OP_WRITE,  15,  0, 16'h2AAA, 1, 16'h2AAA,      0, 0},
    '{16,  OP_ENERGY, 15, 15, 16'h0000, 0, 0, 0, 0},
    '{16,  OP_TRIAL,   0,  0, 16'h5555, 0, 0, 0, 0},
    '{1,   OP_ENERGY,  0,  0, 16'h0000, 1, 16'h0000, -65536, 0},
    '{1,   OP_TRIAL,   0,  0, 16'h4000, 0, 0, 0, 0},
    '{1,   OP_WRITE,   1,  0, 16'h1111, 1, 16'h0000,      0, 1},
    '{1,   OP_READ,    0,  1, 16'h0000, 1, 16'h0000,      0, 1},
    '{0,   OP_READ,    0,  0, 16'h0000, 1, 16'h0000,      0, 1},
    '{0,   OP_ENERGY,  0,  0, 16'h0000, 1, 16'h0000,      0, 1},
    '{127, OP_READ,   16,  3, 16'h0000, 1, 16'h0000,      0, 0},
    '{127, OP_ENERGY, 63, 63, 16'h0000, 0, 0, 0, 0},
    '{127, OP_TRIAL,  63,  0, 16'h0001, 0, 0, 0, 0},
    '{2,   OP_ENERGY,  1,  1, 16'h0000, 0, 0, 0, 0}
  };

  // Side, sender gap and receiver gap of each random phase.
  int phase_side [N_PHASES] = '{2, 64, 7, 1, 37, 127, 64, 0};
  int phase_send [N_PHASES] = '{14, 0, 14, 0, 14, 14, 0, 14};
  int phase_rdy  [N_PHASES] = '{14, 0, 14, 14, 14, 0, 14, 14};

  xy_lattice_site_energy u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #2 clk_i = ~clk_i;

  // Cosine of a quarter-turn step in Q14, from a Taylor series in Q30.
  function automatic int quarter_cos(int unsigned m);
    longint unsigned th;
    longint unsigned th2;
    longint unsigned term;
    longint          acc;
    th   = (64'd1686629713 * longint'(m)) / 256;
    th2  = (th * th) >> 30;
    term = 64'd1 << 30;
    acc  = longint'(64'd1 << 30);
    for (int n = 1; n <= 12; n++) begin
      term = ((term * th2) >> 30) / longint'((2 * n - 1) * (2 * n));
      if (n % 2 == 1) begin
        acc = acc - longint'(term);
      end else begin
        acc = acc + longint'(term);
      end
    end
    if (acc < 0) begin
      acc = 0;
    end
    if (acc > longint'(64'd1 << 30)) begin
      acc = longint'(64'd1 << 30);
    end
    return int'((longint'(acc) + 32768) >>> 16);
  endfunction

  function automatic int cos_at(logic [15:0] d);
    return cos_lut[d[15:6]];
  endfunction

  // Expected beat for one item; updates the local lattice copy.
  function automatic site_res_t site_response(op_e op, logic [5:0] row, logic [5:0] col,
                                              logic [15:0] ang);
    site_res_t   r;
    int unsigned eff;
    logic [5:0]  lc, rc, ur, dr;
    logic [15:0] centre;
    int          acc;
    r   = '0;
    eff = (side_cfg > 7'd64) ? 64 : int'(side_cfg);
    if (row >= eff || col >= eff) begin
      r.bad = 1'b1;
      return r;
    end
    if (op == OP_WRITE) begin
      spin_mem[{row, col}] = ang;
    end
    r.angle_out = spin_mem[{row, col}];
    if (op == OP_ENERGY || op == OP_TRIAL) begin
      centre = (op == OP_TRIAL) ? ang : r.angle_out;
      lc = (col == 6'd0) ? 6'(eff - 1) : col - 6'd1;
      rc = (int'(col) + 1 == eff) ? 6'd0 : col + 6'd1;
      ur = (row == 6'd0) ? 6'(eff - 1) : row - 6'd1;
      dr = (int'(row) + 1 == eff) ? 6'd0 : row + 6'd1;
      acc = cos_at(spin_mem[{row, lc}] - centre) + cos_at(spin_mem[{row, rc}] - centre)
          + cos_at(spin_mem[{ur, col}] - centre) + cos_at(spin_mem[{dr, col}] - centre);
      r.energy = ENERGY_W'(-acc);
    end
    return r;
  endfunction

  // Lattice starts at zero; the cosine table is built by quadrant symmetry.
  initial begin
    foreach (spin_mem[i]) begin
      spin_mem[i] = '0;
    end
    for (int k = 0; k < 1024; k++) begin
      case (k / 256)
        0:       cos_lut[k] = quarter_cos(k % 256);
        1:       cos_lut[k] = -quarter_cos(256 - k % 256);
        2:       cos_lut[k] = -quarter_cos(k % 256);
        default: cos_lut[k] = quarter_cos(256 - k % 256);
      endcase
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > LIMIT_CYCLES) begin
      $display("xy_lattice_site_energy_test: errors");
      $finish;
    end
  end

  // Beat monitor: result check first, then prediction of accepted items.
  site_res_t   mon_exp;
  site_res_t   mon_act;
  site_res_t   mon_pred;
  pinned_res_t mon_pin;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_we_i) begin
        side_cfg = cfg_wdata_i;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        mon_act.angle_out = m_axis_tdata[15:0];
        mon_act.energy    = m_axis_tdata[33:16];
        mon_act.bad       = m_axis_tuser;
        if (site_res_q.size() == 0) begin
          $error("result beat with no item outstanding: angle %0h energy %0d bad %0b",
                 mon_act.angle_out, mon_act.energy, mon_act.bad);
          err_count++;
        end else begin
          mon_exp = site_res_q.pop_front();
          if (mon_act.angle_out !== mon_exp.angle_out) begin
            $error("stored_angle: expected %0h, actual %0h", mon_exp.angle_out,
                   mon_act.angle_out);
            err_count++;
          end
          if (mon_act.energy !== mon_exp.energy) begin
            $error("energy: expected %0d, actual %0d", mon_exp.energy, mon_act.energy);
            err_count++;
          end
          if (mon_act.bad !== mon_exp.bad) begin
            $error("bad_site: expected %0b, actual %0b", mon_exp.bad, mon_act.bad);
            err_count++;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        mon_pred = site_response(op_e'(s_axis_tuser), s_axis_tdata[5:0],
                                 s_axis_tdata[11:6], s_axis_tdata[27:12]);
        mon_pin  = pinned_res_q.pop_front();
        site_res_q.push_back(mon_pin.pinned ? mon_pin.res : mon_pred);
      end
    end
  end

  // Result sink with random back-pressure and one long hold-off.
  initial begin : result_sink
    int stall;
    while (!rst_ni) @(posedge clk_i);
    forever begin
      stall = (rdy_gap_max > 0) ? $urandom_range(0, rdy_gap_max) : 0;
      if (hold_req) begin
        hold_req = 1'b0;
        stall    = HOLD_CYCLES;
      end
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
    end
  end

  // Offer one item after a random gap and wait until it is taken.
  task automatic send_item(op_e op, logic [5:0] row, logic [5:0] col, logic [15:0] ang);
    int gap;
    gap = (send_gap_max > 0) ? $urandom_range(0, send_gap_max) : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tuser  <= op;
    s_axis_tdata  <= {4'b0, ang, col, row};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // Let every outstanding result drain, then hold the input idle.
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (site_res_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_side(int side);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= 7'(side);
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  function automatic logic [5:0] pick_coord(int unsigned eff);
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (eff == 0 || sel < 12) begin
      return 6'($urandom_range(0, 63));
    end
    if (sel < 34) begin
      return 6'd0;
    end
    if (sel < 56) begin
      return 6'(eff - 1);
    end
    return 6'($urandom_range(0, eff - 1));
  endfunction

  // Main sequence: reset, directed table, then random phases.
  initial begin : stimulus
    int           cur_side;
    int unsigned  eff;
    int unsigned  sel;
    op_e          op;
    logic [15:0]  ang;
    pinned_res_t  pin;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    send_gap_max = 3;
    rdy_gap_max  = 3;
    cur_side     = 64;
    for (int i = 0; i < N_DIRECTED; i++) begin
      if (directed_rows[i].side != cur_side) begin
        settle();
        write_side(directed_rows[i].side);
        cur_side = directed_rows[i].side;
      end
      pin.pinned        = directed_rows[i].pinned;
      pin.res.angle_out = 16'(directed_rows[i].e_angle);
      pin.res.energy    = ENERGY_W'(directed_rows[i].e_energy);
      pin.res.bad       = 1'(directed_rows[i].e_bad);
      pinned_res_q.push_back(pin);
      send_item(directed_rows[i].op, 6'(directed_rows[i].row), 6'(directed_rows[i].col),
                directed_rows[i].angle);
    end

    for (int p = 0; p < N_PHASES; p++) begin
      settle();
      cur_side = (p == N_PHASES - 1) ? $urandom_range(3, 63) : phase_side[p];
      write_side(cur_side);
      eff          = (cur_side > 64) ? 64 : cur_side;
      send_gap_max = phase_send[p];
      rdy_gap_max  = phase_rdy[p];
      // Long receiver hold-off while the sender keeps offering.
      if (p == 6) begin
        hold_req = 1'b1;
      end
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        sel = $urandom_range(0, 99);
        op  = op_e'((sel < 35) ? OP_WRITE : (sel < 50) ? OP_READ :
                    (sel < 75) ? OP_ENERGY : OP_TRIAL);
        if ($urandom_range(0, 9) == 0) begin
          case ($urandom_range(0, 3))
            0:       ang = 16'h0000;
            1:       ang = 16'hFFFF;
            2:       ang = 16'h8000;
            default: ang = 16'h4000;
          endcase
        end else begin
          ang = 16'($urandom_range(0, 65535));
        end
        pin = '0;
        pinned_res_q.push_back(pin);
        send_item(op, pick_coord(eff), pick_coord(eff), ang);
      end
    end

    settle();
    if (err_count == 0) begin
      $display("xy_lattice_site_energy_test: clean");
    end else begin
      $display("xy_lattice_site_energy_test: errors");
    end
    $finish;
  end

endmodule
